@@ rtl/lfrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_pkg: shared types and constants for the largest free region selector
// Configuration bundle, register indexes, port sizing and page rounding helper.
// ----------------------------------------------------------------------------
package lfrs_pkg;

   localparam int unsigned PAGE_BYTES_DEFAULT = 4096;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [31:0] KIND_AVAILABLE = 32'd1;

   localparam logic [63:0] LOAD_TOP_RESET   = 64'd0;
   localparam logic [63:0] MIN_BYTES_RESET  = 64'd2097152;
   localparam logic [63:0] ADDR_LIMIT_RESET = 64'h0000_0000_FFFF_FFFF;

   // Register index, taken from the byte address bits above the 8-byte word
   typedef enum logic [1:0] {
      REG_LOAD_TOP   = 2'd0,
      REG_MIN_BYTES  = 2'd1,
      REG_ADDR_LIMIT = 2'd2
   } reg_index_type;

   // Live configuration as seen by the datapath
   typedef struct packed {
      logic [63:0] image_floor;   // load top rounded up to a page
      logic [63:0] min_bytes;
      logic [63:0] addr_limit;
   } cfg_type;

   function automatic logic [63:0] page_round_up(input logic [63:0] value,
                                                 input logic [63:0] mask);
      return (value + mask) & ~mask;
   endfunction

endpackage

@@ rtl/lfrs_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_csr: configuration register file
// APB-style slave holding load_top, min_bytes and addr_limit.
// ----------------------------------------------------------------------------
module lfrs_csr import lfrs_pkg::*; #(
   parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   localparam logic [63:0] PageMask = 64'(PAGE_BYTES) - 64'd1;

   logic [63:0]   load_top_ff;
   logic [63:0]   image_floor_ff;
   logic [63:0]   min_bytes_ff;
   logic [63:0]   addr_limit_ff;
   logic          write_en;
   reg_index_type reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_top_ff    <= LOAD_TOP_RESET;
         image_floor_ff <= page_round_up(LOAD_TOP_RESET, PageMask);
         min_bytes_ff   <= MIN_BYTES_RESET;
         addr_limit_ff  <= ADDR_LIMIT_RESET;
      end else if (write_en) begin
         unique case (reg_index)
            REG_LOAD_TOP: begin
               load_top_ff    <= csr_pwdata;
               // keep the page-rounded copy so the datapath skips one add
               image_floor_ff <= page_round_up(csr_pwdata, PageMask);
            end
            REG_MIN_BYTES:  min_bytes_ff  <= csr_pwdata;
            REG_ADDR_LIMIT: addr_limit_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_LOAD_TOP:   csr_prdata = load_top_ff;
         REG_MIN_BYTES:  csr_prdata = min_bytes_ff;
         REG_ADDR_LIMIT: csr_prdata = addr_limit_ff;
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.image_floor = image_floor_ff;
   assign cfg.min_bytes   = min_bytes_ff;
   assign cfg.addr_limit  = addr_limit_ff;

endmodule

@@ rtl/lfrs_weigh.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_weigh: region window and best-so-far tracking
// Stage one forms the aligned window of each region; stage two weighs it
// against the best and hands the final best out on the last region.
// ----------------------------------------------------------------------------
module lfrs_weigh import lfrs_pkg::*; #(
   parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_region_base,
   input  logic [63:0] req_region_length,
   input  logic [31:0] req_region_kind,
   input  logic        req_is_last,
   output logic        fin_valid,
   input  logic        fin_ready,
   output logic [63:0] fin_base,
   output logic [63:0] fin_length
);

   localparam logic [63:0] PageMask = 64'(PAGE_BYTES) - 64'd1;

   logic        s1_valid_ff;
   logic        s1_use_ff;
   logic        s1_last_ff;
   logic [63:0] s1_start_ff;
   logic [63:0] s1_end_ff;
   logic        s1_use_in;
   logic [63:0] s1_start_in;
   logic [63:0] s1_end_in;
   logic        s1_load;
   logic        s1_go;

   logic [63:0] best_base_ff;
   logic [63:0] best_length_ff;
   logic [63:0] best_base_in;
   logic [63:0] best_length_in;

   logic        fin_valid_ff;
   logic [63:0] fin_base_ff;
   logic [63:0] fin_length_ff;
   logic        fin_load;

   logic [63:0] win_length;
   logic        win_take;

   // Stage one: end address and aligned start
   assign s1_use_in   = (req_region_kind == KIND_AVAILABLE) && (req_region_length != 64'd0);
   assign s1_end_in   = req_region_base + req_region_length;
   assign s1_start_in = page_round_up((req_region_base < cfg.image_floor) ?
                                      cfg.image_floor : req_region_base, PageMask);

   // Non-last transactions never need the final register, so they drain freely
   assign s1_go     = s1_valid_ff && (!s1_last_ff || !fin_valid_ff || fin_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign s1_load   = req_valid && req_ready;
   assign fin_load  = s1_go && s1_last_ff;

   // Stage two: aligned length and comparison with the best
   assign win_length = (s1_end_ff - s1_start_ff) & ~PageMask;
   assign win_take   = s1_use_ff && (s1_start_ff < s1_end_ff)
                       && (win_length >= cfg.min_bytes) && (win_length > best_length_ff);

   assign best_base_in   = win_take ? s1_start_ff : best_base_ff;
   assign best_length_in = win_take ? win_length  : best_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         fin_valid_ff   <= 1'b0;
         best_base_ff   <= '0;
         best_length_ff <= '0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (fin_load) begin
            fin_valid_ff <= 1'b1;
         end else if (fin_ready) begin
            fin_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            // clear the best once the map ends
            best_base_ff   <= s1_last_ff ? 64'd0 : best_base_in;
            best_length_ff <= s1_last_ff ? 64'd0 : best_length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_use_ff   <= s1_use_in;
         s1_last_ff  <= req_is_last;
         s1_start_ff <= s1_start_in;
         s1_end_ff   <= s1_end_in;
      end
      if (fin_load) begin
         fin_base_ff   <= best_base_in;
         fin_length_ff <= best_length_in;
      end
   end

   assign fin_valid  = fin_valid_ff;
   assign fin_base   = fin_base_ff;
   assign fin_length = fin_length_ff;

`ifndef SYNTHESIS
   a_best_cleared: assert property (@(posedge clock) disable iff (reset)
      fin_load |=> (best_length_ff == 64'd0) && (best_base_ff == 64'd0))
      else $error("best not cleared after last region");
   a_best_len_aligned: assert property (@(posedge clock) disable iff (reset)
      (best_length_ff & PageMask) == 64'd0)
      else $error("best length not page aligned");
   a_best_base_aligned: assert property (@(posedge clock) disable iff (reset)
      (best_base_ff & PageMask) == 64'd0)
      else $error("best base not page aligned");
`endif

endmodule

@@ rtl/lfrs_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_emit: claim decision and result register
// Checks the final best against the limits, clamps the length, holds result.
// ----------------------------------------------------------------------------
module lfrs_emit import lfrs_pkg::*; #(
   parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        fin_valid,
   output logic        fin_ready,
   input  logic [63:0] fin_base,
   input  logic [63:0] fin_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_claim_ok,
   output logic [63:0] rsp_arena_base,
   output logic [63:0] rsp_arena_length
);

   localparam logic [63:0] PageMask = 64'(PAGE_BYTES) - 64'd1;

   logic        rsp_valid_ff;
   logic        claim_ok_ff;
   logic [63:0] arena_base_ff;
   logic [63:0] arena_length_ff;
   logic        claim_ok_in;
   logic [63:0] arena_base_in;
   logic [63:0] arena_length_in;
   logic [63:0] clamp_length;
   logic        load;

   assign fin_ready = !rsp_valid_ff || rsp_ready;
   assign load      = fin_valid && fin_ready;

   assign claim_ok_in = (fin_length != 64'd0) && (fin_length >= cfg.min_bytes)
                        && (fin_base <= cfg.addr_limit);
   assign clamp_length    = (fin_length > cfg.addr_limit) ? (cfg.addr_limit & ~PageMask)
                                                          : fin_length;
   assign arena_base_in   = claim_ok_in ? fin_base : 64'd0;
   assign arena_length_in = claim_ok_in ? clamp_length : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         claim_ok_ff     <= claim_ok_in;
         arena_base_ff   <= arena_base_in;
         arena_length_ff <= arena_length_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_claim_ok     = claim_ok_ff;
   assign rsp_arena_base   = arena_base_ff;
   assign rsp_arena_length = arena_length_ff;

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !claim_ok_ff) |-> (arena_base_ff == 64'd0) && (arena_length_ff == 64'd0))
      else $error("failed claim carries nonzero arena");
   a_len_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (arena_length_ff & PageMask) == 64'd0)
      else $error("arena length not page aligned");
   a_base_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && claim_ok_ff) |-> (arena_base_ff <= cfg.addr_limit))
      else $error("arena base beyond address limit");
`endif

endmodule

@@ rtl/largest_free_region_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_free_region_select: pick the longest usable region of a memory map
// Regions stream in one per transaction; the map's last region yields a claim.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one memory-map region per transaction (base, length, raw type
//   code, last flag). A transaction is taken on every cycle the channel offers
//   one while req_ready is high; the block sustains one region per clock.
//   rsp channel: one transaction per map, issued for the region marked last,
//   carrying claim_ok, the page-aligned arena base and its clamped length.
//   The result passes through the window stage register, the weigh stage's
//   hand-off register and the result register.
//   The best-so-far compare in the weigh stage is combinational, so a region
//   can follow in every cycle unless a stalled result holds req_ready low.
//   csr port: load_top, min_bytes and addr_limit at byte offsets 0, 8 and 16,
//   64-bit data; write them only while no map is in flight.
//   Reset empties the pipeline, clears the best-so-far and loads the register
//   defaults. While the receiver stalls a pending result, ordinary regions
//   still flow; a further last region is held in the hand-off register, and
//   req_ready drops once yet another last region reaches the window stage.
// ----------------------------------------------------------------------------
module largest_free_region_select import lfrs_pkg::*; #(
   parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [63:0]           req_region_base,
   input  logic [63:0]           req_region_length,
   input  logic [31:0]           req_region_kind,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_claim_ok,
   output logic [63:0]           rsp_arena_base,
   output logic [63:0]           rsp_arena_length,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg;
   logic        fin_valid;
   logic        fin_ready;
   logic [63:0] fin_base;
   logic [63:0] fin_length;

   lfrs_csr #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lfrs_weigh #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_weigh (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_region_base   (req_region_base),
      .req_region_length (req_region_length),
      .req_region_kind   (req_region_kind),
      .req_is_last       (req_is_last),
      .fin_valid         (fin_valid),
      .fin_ready         (fin_ready),
      .fin_base          (fin_base),
      .fin_length        (fin_length)
   );

   lfrs_emit #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .fin_valid        (fin_valid),
      .fin_ready        (fin_ready),
      .fin_base         (fin_base),
      .fin_length       (fin_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_claim_ok     (rsp_claim_ok),
      .rsp_arena_base   (rsp_arena_base),
      .rsp_arena_length (rsp_arena_length)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for largest_free_region_select
// Streams memory-map regions through the block under bursty sending and a
// stalling receiver. A behavioural predictor tracks the longest usable region
// per map and checks every claim field by field. The register settings change
// between maps and include their extremes.
// ----------------------------------------------------------------------------
module tb;
   import lfrs_pkg::*;

   localparam int unsigned PAGE_BYTES    = PAGE_BYTES_DEFAULT;
   localparam logic [63:0] PAGE_MASK     = 64'(PAGE_BYTES) - 64'd1;
   localparam logic [63:0] ALL_ONES      = ~64'd0;
   localparam int unsigned ITEM_TARGET   = 1250;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned CYCLE_LIMIT   = 500000;

   localparam logic [CSR_ADDR_W-1:0] ADDR_LOAD_TOP   = {REG_LOAD_TOP, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_MIN_BYTES  = {REG_MIN_BYTES, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_ADDR_LIMIT = {REG_ADDR_LIMIT, 3'b000};

   localparam logic [31:0] KIND_NONE     = 32'd0;
   localparam logic [31:0] KIND_RESERVED = 32'd2;
   localparam logic [31:0] KIND_ALIAS    = 32'h8000_0001;
   localparam logic [31:0] KIND_TOP      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [63:0] base;
      logic [63:0] length;
      logic [31:0] kind;
      logic        last;
   } region_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] base;
      logic [63:0] length;
   } claim_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [63:0]           req_region_base = '0;
   logic [63:0]           req_region_length = '0;
   logic [31:0]           req_region_kind = '0;
   logic                  req_is_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_claim_ok;
   logic [63:0]           rsp_arena_base;
   logic [63:0]           rsp_arena_length;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [63:0] pred_load_top   = LOAD_TOP_RESET;
   logic [63:0] pred_min_bytes  = MIN_BYTES_RESET;
   logic [63:0] pred_addr_limit = ADDR_LIMIT_RESET;
   logic [63:0] lead_base   = '0;
   logic [63:0] lead_length = '0;
   claim_type   claim_q[$];

   int unsigned regions_sent    = 0;
   int unsigned claims_granted  = 0;
   int unsigned claims_refused  = 0;
   int unsigned settings_used   = 1;
   int unsigned error_count     = 0;
   int unsigned cycle_count     = 0;
   int unsigned burst_left      = 0;
   bit          steady_send     = 1'b0;
   int unsigned hold_requests   = 0;
   int unsigned hold_served     = 0;
   int unsigned hold_left       = 0;
   int unsigned stall_pct       = 0;
   int unsigned pace_left       = 0;

   largest_free_region_select #(.PAGE_BYTES(PAGE_BYTES)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_region_base   (req_region_base),
      .req_region_length (req_region_length),
      .req_region_kind   (req_region_kind),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_claim_ok      (rsp_claim_ok),
      .rsp_arena_base    (rsp_arena_base),
      .rsp_arena_length  (rsp_arena_length),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] align_up(input logic [63:0] addr);
      return (addr + PAGE_MASK) & ~PAGE_MASK;
   endfunction

   function automatic region_type mk_region(input logic [63:0] base,
                                            input logic [63:0] length,
                                            input logic [31:0] kind, input logic last);
      region_type r;
      r.base   = base;
      r.length = length;
      r.kind   = kind;
      r.last   = last;
      return r;
   endfunction

   // Weigh one region against the best so far; close the map on the last one.
   task automatic predict_claim(input region_type r);
      logic [63:0] stop, first, span, floor_addr;
      claim_type   c;
      if (r.kind == KIND_AVAILABLE && r.length != 64'd0) begin
         stop       = r.base + r.length;
         floor_addr = align_up(pred_load_top);
         first      = align_up((r.base < floor_addr) ? floor_addr : r.base);
         if (first < stop) begin
            span = (stop - first) & ~PAGE_MASK;
            if (span >= pred_min_bytes && span > lead_length) begin
               lead_base   = first;
               lead_length = span;
            end
         end
      end
      if (r.last) begin
         c.ok     = lead_length != 64'd0 && lead_length >= pred_min_bytes &&
                    lead_base <= pred_addr_limit;
         c.base   = c.ok ? lead_base : 64'd0;
         c.length = !c.ok ? 64'd0 :
                    (lead_length > pred_addr_limit) ? (pred_addr_limit & ~PAGE_MASK) :
                    lead_length;
         claim_q.push_back(c);
         lead_base   = '0;
         lead_length = '0;
      end
   endtask

   task automatic send_region(input region_type r);
      int unsigned gap;
      req_valid         <= 1'b1;
      req_region_base   <= r.base;
      req_region_length <= r.length;
      req_region_kind   <= r.kind;
      req_is_last       <= r.last;
      do @(posedge clock); while (!req_ready);
      predict_claim(r);
      regions_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0 && !steady_send) begin
         gap        = $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, wait out every claim and let trailing regions clear the pipe.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (claim_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [63:0] value,
                            input bit final_write);
      if (!csr_psel) begin
         csr_psel   <= 1'b1;
         csr_pwrite <= 1'b1;
      end
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (final_write) begin
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
      end
      case (addr)
         ADDR_LOAD_TOP:   pred_load_top   = value;
         ADDR_MIN_BYTES:  pred_min_bytes  = value;
         ADDR_ADDR_LIMIT: pred_addr_limit = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [63:0] load_top, input logic [63:0] min_bytes,
                             input logic [63:0] addr_limit);
      drain_pipeline();
      write_csr(ADDR_LOAD_TOP, load_top, 1'b0);
      write_csr(ADDR_MIN_BYTES, min_bytes, 1'b0);
      write_csr(ADDR_ADDR_LIMIT, addr_limit, 1'b1);
      settings_used++;
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] claim mismatch on %s: got 0x%016h, want 0x%016h",
               $time, field, got, want);
      error_count++;
   endtask

   // Claim checker
   always @(posedge clock) begin : claim_check
      claim_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (claim_q.size() == 0) begin
            report_mismatch("unexpected transaction", {63'd0, rsp_claim_ok}, 64'd0);
         end else begin
            want = claim_q.pop_front();
            if (rsp_claim_ok !== want.ok)
               report_mismatch("claim_ok", {63'd0, rsp_claim_ok}, {63'd0, want.ok});
            if (rsp_arena_base !== want.base)
               report_mismatch("arena_base", rsp_arena_base, want.base);
            if (rsp_arena_length !== want.length)
               report_mismatch("arena_length", rsp_arena_length, want.length);
            if (want.ok) claims_granted++;
            else claims_refused++;
         end
      end
   end

   // Receiver: stall at a rate that changes now and then; hold off on request.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (pace_left == 0) begin
            case ($urandom_range(0, 4))
               0, 1:    stall_pct <= 0;
               2:       stall_pct <= 20;
               3:       stall_pct <= 50;
               default: stall_pct <= 85;
            endcase
            pace_left <= $urandom_range(20, 120);
         end else begin
            pace_left <= pace_left - 1;
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d claims outstanding",
                  cycle_count, claim_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic region_type random_region(input region_type prev);
      region_type r;
      r.last = 1'b0;
      if (prev.length != 64'd0 && $urandom_range(0, 9) == 0) begin
         // same length further up: a tie must keep the earlier region
         r.base   = prev.base + (64'($urandom_range(1, 1024)) << 12);
         r.length = prev.length;
         r.kind   = KIND_AVAILABLE;
         return r;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            r.base = 64'($urandom_range(0, 32'hF_FFFF)) << 12;
            if ($urandom_range(0, 3) == 0) r.base += 64'($urandom_range(1, PAGE_BYTES - 1));
         end
         5, 6:    r.base = {28'd0, 4'($urandom_range(0, 15)), 32'($urandom)};
         7:       r.base = {$urandom, $urandom};
         8:       r.base = ALL_ONES - 64'($urandom_range(0, 32'hFF_FFFF));
         default: r.base = 64'($urandom_range(0, 32'h1F_FFFF));
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            r.length = 64'($urandom_range(1, 512)) << 20;
            if ($urandom_range(0, 2) == 0) r.length += 64'($urandom_range(1, 8191));
         end
         6:       r.length = 64'($urandom_range(0, 3 * PAGE_BYTES));
         7:       r.length = {$urandom, $urandom};
         8:       r.length = 64'd0;
         default: r.length = {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
      endcase
      case ($urandom_range(0, 9))
         0:       r.kind = $urandom;
         1:       r.kind = KIND_RESERVED;
         2:       r.kind = KIND_NONE;
         default: r.kind = KIND_AVAILABLE;
      endcase
      return r;
   endfunction

   task automatic apply_random_config();
      logic [63:0] load_top, min_bytes, addr_limit;
      case ($urandom_range(0, 5))
         0:       load_top = LOAD_TOP_RESET;
         1:       load_top = {$urandom, $urandom};
         2:       load_top = ALL_ONES - 64'($urandom_range(0, 32'h3FFF));
         default: load_top = 64'($urandom_range(0, 32'h3FFF_FFFF));
      endcase
      case ($urandom_range(0, 9))
         0:       min_bytes = 64'd0;
         1:       min_bytes = 64'(PAGE_BYTES);
         2:       min_bytes = 64'($urandom_range(0, 32'h0400_0000));
         3:       min_bytes = ALL_ONES;
         4:       min_bytes = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: min_bytes = MIN_BYTES_RESET;
      endcase
      case ($urandom_range(0, 7))
         0:       addr_limit = ALL_ONES;
         1:       addr_limit = 64'd0;
         2:       addr_limit = {$urandom, $urandom};
         3, 4:    addr_limit = {28'd0, 4'($urandom_range(0, 15)), 32'($urandom)};
         default: addr_limit = ADDR_LIMIT_RESET;
      endcase
      set_config(load_top, min_bytes, addr_limit);
   endtask

   // Reset settings: ignored kinds, skips, a tie, refusals, clamp and wrap.
   task automatic test_directed_regions();
      send_region(mk_region(64'h0010_0000, 64'h0100_0000, KIND_NONE, 1'b0));
      send_region(mk_region(64'h0010_0000, 64'h0100_0000, KIND_TOP, 1'b0));
      send_region(mk_region(64'h0010_0000, 64'h0100_0000, KIND_ALIAS, 1'b0));
      send_region(mk_region(64'h0010_0000, 64'd0, KIND_AVAILABLE, 1'b0));
      send_region(mk_region(64'h0000_1000, 64'h0030_0000, KIND_AVAILABLE, 1'b0));
      send_region(mk_region(64'h0010_0001, 64'h0020_0000, KIND_AVAILABLE, 1'b0));
      send_region(mk_region(64'h4000_0000, 64'h0030_0000, KIND_AVAILABLE, 1'b1));
      send_region(mk_region(64'd0, ALL_ONES, KIND_RESERVED, 1'b1));
      send_region(mk_region(64'h1_0000_0000, 64'h1000_0000, KIND_AVAILABLE, 1'b1));
      send_region(mk_region(64'd0, ALL_ONES, KIND_AVAILABLE, 1'b1));
      send_region(mk_region(64'hFFFF_FFFF_FFFF_F000, 64'h1_0000, KIND_AVAILABLE, 1'b0));
      send_region(mk_region(64'hFFFF_FFFF_FFFF_F001, 64'h40_0000, KIND_AVAILABLE, 1'b1));
      send_region(mk_region(64'h5000, 64'h800, KIND_AVAILABLE, 1'b0));
      send_region(mk_region(64'h5001, 64'h800, KIND_AVAILABLE, 1'b1));
   endtask

   task automatic test_register_extremes();
      set_config(64'h1234_5678, 64'(PAGE_BYTES), ALL_ONES);
      send_region(mk_region(64'd0, 64'h2000_0000, KIND_AVAILABLE, 1'b0));
      send_region(mk_region(64'h4000_0000, 64'h0100_0000, KIND_AVAILABLE, 1'b1));
      // load top at the very top wraps to a zero floor; a zero limit clamps to zero
      set_config(ALL_ONES, 64'd0, 64'd0);
      send_region(mk_region(64'h2000, 64'h3000, KIND_AVAILABLE, 1'b1));
      send_region(mk_region(64'd0, 64'h5000, KIND_AVAILABLE, 1'b1));
      set_config(LOAD_TOP_RESET, ALL_ONES, ALL_ONES);
      send_region(mk_region(64'd0, ALL_ONES, KIND_AVAILABLE, 1'b1));
      set_config(LOAD_TOP_RESET, 64'd0, ALL_ONES);
      send_region(mk_region(64'd0, 64'h800, KIND_AVAILABLE, 1'b1));
      set_config(64'hFFFF_FFFF_FFFF_E001, 64'd0, ADDR_LIMIT_RESET);
      send_region(mk_region(64'h1000, ALL_ONES - 64'h1000, KIND_AVAILABLE, 1'b1));
      set_config(LOAD_TOP_RESET, MIN_BYTES_RESET, ADDR_LIMIT_RESET);
      send_region(mk_region(64'h8000_0000, 64'h1_0000_0000, KIND_AVAILABLE, 1'b1));
   endtask

   // Hold the result channel off while regions keep coming, so the input stalls.
   task automatic test_output_stall();
      region_type r;
      drain_pipeline();
      steady_send   = 1'b1;
      hold_requests <= hold_requests + 1;
      r = '0;
      repeat (60) begin
         r      = random_region(r);
         r.last = ($urandom_range(0, 1) == 0);
         send_region(r);
      end
      r      = random_region(r);
      r.last = 1'b1;
      send_region(r);
      steady_send = 1'b0;
      drain_pipeline();
   endtask

   task automatic test_random_maps();
      region_type  r;
      int unsigned map_len;
      r = '0;
      while (regions_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 39) == 0) apply_random_config();
         map_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         for (int unsigned k = 0; k < map_len; k++) begin
            r = random_region(r);
            if (k == map_len - 1) r.last = 1'b1;
            else r.last = ($urandom_range(0, 19) == 0);
            send_region(r);
         end
      end
      drain_pipeline();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_regions();
      test_register_extremes();
      test_output_stall();
      test_random_maps();
      drain_pipeline();
      $display("Covered %0d regions over %0d register settings", regions_sent, settings_used);
      $display("Claims checked: %0d granted, %0d refused, %0d mismatches",
               claims_granted, claims_refused, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ largest_free_region_select.f @@
rtl/lfrs_pkg.sv
rtl/lfrs_csr.sv
rtl/lfrs_weigh.sv
rtl/lfrs_emit.sv
rtl/largest_free_region_select.sv
tb/tb.sv
